>>> rtl/rrrt_pkg.sv
// ----------------------------------------------------------------------------
// rrrt_pkg
// Shared types and codes for the register rewrite rule table: payload
// structs, op and action codes, table sizing and sequencer states.
// ----------------------------------------------------------------------------
package rrrt_pkg;

    localparam int RULE_SLOTS = 16;
    localparam int SLOT_W     = $clog2(RULE_SLOTS);
    localparam int COUNT_W    = $clog2(RULE_SLOTS + 1);
    localparam int DATA_W     = 32;
    localparam int STEP_W     = $clog2(DATA_W);

    localparam logic [1:0] OP_APPLY  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] KIND_SET = 3'd0;
    localparam logic [2:0] KIND_ADD = 3'd1;
    localparam logic [2:0] KIND_SUB = 3'd2;
    localparam logic [2:0] KIND_MUL = 3'd3;
    localparam logic [2:0] KIND_DIV = 3'd4;

    typedef struct packed {
        logic [1:0]               op;
        logic [7:0]               slave_addr;
        logic [15:0]              reg_num;
        logic [2:0]               mod_kind;
        logic signed [DATA_W-1:0] mod_param;
        logic signed [DATA_W-1:0] value_in;
    } rrrt_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic                     status;
    } rrrt_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_NEG_A,
        ST_NEG_B,
        ST_ITER,
        ST_NEG_Q,
        ST_FINISH
    } rrrt_state_t;

endpackage

>>> rtl/register_rewrite_rule_table_unit.sv
// ----------------------------------------------------------------------------
// register_rewrite_rule_table_unit
// Match-action table of value rewrite rules keyed by slave and register
// address, with one shared adder driving a small sequencer.
// ----------------------------------------------------------------------------
// One item is in flight at a time; in_ready is high only while the sequencer
// is idle, and a finished result may still wait in the output register while
// the next item is taken. Every op but clear first walks the stored rules one
// slot per cycle, then the finish state loads the output register once that
// register is free. Overwrite, add and subtract finish inside the walk.
// Multiply runs 32 shift-add steps and divide fixes both operand signs
// (NEG_A, NEG_B), runs 32 restoring steps and fixes the quotient sign
// (NEG_Q), all on the same 33-bit adder. Clear skips the walk.
module register_rewrite_rule_table_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rrrt_pkg::rrrt_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rrrt_pkg::rrrt_out_t out_data
);
    import rrrt_pkg::*;

    rrrt_state_t           state_reg, state_next;
    rrrt_in_t              req_reg, req_next;
    logic [COUNT_W-1:0]    idx_reg, idx_next;
    logic [COUNT_W-1:0]    used_count_reg, used_count_next;
    logic [RULE_SLOTS-1:0] active_reg, active_next;
    logic [DATA_W-1:0]     a_reg, a_next;
    logic [DATA_W-1:0]     b_reg, b_next;
    logic [DATA_W-1:0]     acc_reg, acc_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic                  div_reg, div_next;
    logic [DATA_W-1:0]     res_reg, res_next;
    logic                  status_reg, status_next;
    logic                  out_valid_reg, out_valid_next;
    rrrt_out_t             out_data_reg, out_data_next;

    // rule storage
    logic [7:0]        entry_slave_reg    [RULE_SLOTS];
    logic [15:0]       entry_register_reg [RULE_SLOTS];
    logic [2:0]        entry_kind_reg     [RULE_SLOTS];
    logic [DATA_W-1:0] entry_operand_reg  [RULE_SLOTS];

    logic              tbl_we;
    logic              tbl_key_we;
    logic [SLOT_W-1:0] slot;
    logic              at_end;
    logic              key_hit;
    logic [2:0]        cur_kind;
    logic [DATA_W-1:0] cur_operand;

    // shared adder
    logic [DATA_W:0]   alu_a, alu_b;
    logic              alu_cin;
    logic [DATA_W+1:0] alu_sum;
    logic              div_ge;

    assign slot        = idx_reg[SLOT_W-1:0];
    assign at_end      = (idx_reg == used_count_reg);
    assign key_hit     = !at_end && (entry_slave_reg[slot] == req_reg.slave_addr)
                         && (entry_register_reg[slot] == req_reg.reg_num);
    assign cur_kind    = entry_kind_reg[slot];
    assign cur_operand = entry_operand_reg[slot];

    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {{(DATA_W+1){1'b0}}, alu_cin};
    assign div_ge  = alu_sum[DATA_W+1];

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        case (state_reg)
            ST_SCAN:
            begin
                alu_a = {1'b0, req_reg.value_in};
                if (cur_kind == KIND_SUB)
                begin
                    alu_b   = {1'b1, ~cur_operand};
                    alu_cin = 1'b1;
                end
                else
                begin
                    alu_b = {1'b0, cur_operand};
                end
            end
            ST_NEG_A:
            begin
                alu_a   = {1'b0, ~a_reg};
                alu_cin = 1'b1;
            end
            ST_NEG_B:
            begin
                alu_a   = {1'b0, ~b_reg};
                alu_cin = 1'b1;
            end
            ST_ITER:
            begin
                if (div_reg)
                begin
                    // trial subtract of divisor from shifted remainder
                    alu_a   = {acc_reg, a_reg[DATA_W-1]};
                    alu_b   = {1'b1, ~b_reg};
                    alu_cin = 1'b1;
                end
                else
                begin
                    alu_a = {1'b0, acc_reg};
                    alu_b = b_reg[0] ? {1'b0, a_reg} : '0;
                end
            end
            ST_NEG_Q:
            begin
                alu_a   = {1'b0, neg_reg ? ~a_reg : a_reg};
                alu_cin = neg_reg;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        idx_next        = idx_reg;
        used_count_next = used_count_reg;
        active_next     = active_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        neg_next        = neg_reg;
        div_next        = div_reg;
        res_next        = res_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        tbl_we          = 1'b0;
        tbl_key_we      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next    = in_data;
                    idx_next    = '0;
                    res_next    = '0;
                    status_next = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                case (req_reg.op)
                    OP_CLEAR:
                    begin
                        used_count_next = '0;
                        active_next     = '0;
                        state_next      = ST_FINISH;
                    end
                    OP_APPLY:
                    begin
                        if (at_end)
                        begin
                            res_next   = req_reg.value_in;
                            state_next = ST_FINISH;
                        end
                        else if (key_hit && active_reg[slot])
                        begin
                            state_next = ST_FINISH;
                            case (cur_kind)
                                KIND_SET: res_next = cur_operand;
                                KIND_ADD: res_next = alu_sum[DATA_W-1:0];
                                KIND_SUB: res_next = alu_sum[DATA_W-1:0];
                                KIND_MUL:
                                begin
                                    a_next     = req_reg.value_in;
                                    b_next     = cur_operand;
                                    acc_next   = '0;
                                    cnt_next   = STEP_W'(DATA_W - 1);
                                    div_next   = 1'b0;
                                    state_next = ST_ITER;
                                end
                                KIND_DIV:
                                begin
                                    if (cur_operand == '0)
                                    begin
                                        res_next = req_reg.value_in;
                                    end
                                    else
                                    begin
                                        a_next     = req_reg.value_in;
                                        b_next     = cur_operand;
                                        acc_next   = '0;
                                        cnt_next   = STEP_W'(DATA_W - 1);
                                        div_next   = 1'b1;
                                        neg_next   = req_reg.value_in[DATA_W-1]
                                                     ^ cur_operand[DATA_W-1];
                                        state_next = ST_NEG_A;
                                    end
                                end
                                default: res_next = req_reg.value_in;
                            endcase
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    OP_ADD:
                    begin
                        if (key_hit)
                        begin
                            tbl_we            = 1'b1;
                            active_next[slot] = 1'b1;
                            state_next        = ST_FINISH;
                        end
                        else if (at_end)
                        begin
                            // append at the first free slot, which is idx
                            if (used_count_reg < COUNT_W'(RULE_SLOTS))
                            begin
                                tbl_we            = 1'b1;
                                tbl_key_we        = 1'b1;
                                active_next[slot] = 1'b1;
                                used_count_next   = used_count_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (key_hit)
                        begin
                            active_next[slot] = 1'b0;
                            state_next        = ST_FINISH;
                        end
                        else if (at_end)
                        begin
                            status_next = 1'b1;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_NEG_A:
            begin
                if (a_reg[DATA_W-1])
                begin
                    a_next = alu_sum[DATA_W-1:0];
                end
                state_next = ST_NEG_B;
            end
            ST_NEG_B:
            begin
                if (b_reg[DATA_W-1])
                begin
                    b_next = alu_sum[DATA_W-1:0];
                end
                state_next = ST_ITER;
            end
            ST_ITER:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (div_reg)
                begin
                    acc_next = div_ge ? alu_sum[DATA_W-1:0]
                                      : {acc_reg[DATA_W-2:0], a_reg[DATA_W-1]};
                    a_next   = {a_reg[DATA_W-2:0], div_ge};
                end
                else
                begin
                    acc_next = alu_sum[DATA_W-1:0];
                    a_next   = {a_reg[DATA_W-2:0], 1'b0};
                    b_next   = {1'b0, b_reg[DATA_W-1:1]};
                end
                if (cnt_reg == '0)
                begin
                    if (div_reg)
                    begin
                        state_next = ST_NEG_Q;
                    end
                    else
                    begin
                        res_next   = alu_sum[DATA_W-1:0];
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_NEG_Q:
            begin
                res_next   = alu_sum[DATA_W-1:0];
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.value_out = res_reg;
                    out_data_next.status    = status_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_count_reg <= '0;
            active_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        idx_reg      <= idx_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        neg_reg      <= neg_next;
        div_reg      <= div_next;
        res_reg      <= res_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    // slots past used_count are never read, so no reset here
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            entry_kind_reg[slot]    <= req_reg.mod_kind;
            entry_operand_reg[slot] <= req_reg.mod_param;
        end
        if (tbl_key_we)
        begin
            entry_slave_reg[slot]    <= req_reg.slave_addr;
            entry_register_reg[slot] <= req_reg.reg_num;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/rrrt_checker.sv
// ----------------------------------------------------------------------------
// rrrt_checker
// Port-level checks for the rule table: busy after a transfer, held results
// and result fields that follow from the op of each pending item.
// ----------------------------------------------------------------------------
module rrrt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input rrrt_pkg::rrrt_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input rrrt_pkg::rrrt_out_t out_data
);
    import rrrt_pkg::*;

    // ops of items not yet delivered, oldest first
    logic [1:0] op0_reg, op0_next;
    logic [1:0] op1_reg, op1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        op0_next = op0_reg;
        op1_next = op1_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            if (cnt_reg == 2'd0)
            begin
                op0_next = in_data.op;
            end
            else
            begin
                op1_next = in_data.op;
            end
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            op0_next = op1_reg;
            cnt_next = cnt_reg - 1'b1;
        end
        else if (pop && push)
        begin
            if (cnt_reg == 2'd1)
            begin
                op0_next = in_data.op;
            end
            else
            begin
                op0_next = op1_reg;
                op1_next = in_data.op;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op0_reg <= OP_APPLY;
            op1_reg <= OP_APPLY;
            cnt_reg <= 2'd0;
        end
        else
        begin
            op0_reg <= op0_next;
            op1_reg <= op1_next;
            cnt_reg <= cnt_next;
        end
    end

    busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after an input transfer");

    result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result dropped or changed");

    no_result_without_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cnt_reg != 2'd0)
        else $error("result with no pending item");

    zero_value_off_apply: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op0_reg != OP_APPLY |-> out_data.value_out == '0)
        else $error("nonzero value_out for a table op");

    status_only_add_remove: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (op0_reg == OP_APPLY || op0_reg == OP_CLEAR) |-> !out_data.status)
        else $error("status set for apply or clear");

endmodule

bind register_rewrite_rule_table_unit rrrt_checker u_rrrt_checker (.*);

>>> verif/rule_table_checker.sv
// ----------------------------------------------------------------------------
// rule_table_checker
// Watches both channels of the rewrite rule table, keeps its own copy of the
// rule slots, works out the result of every accepted item and compares each
// returned result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rule_table_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  rrrt_pkg::rrrt_in_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  rrrt_pkg::rrrt_out_t out_data,
    output int                  mismatch_count,
    output int                  outstanding
);
    import rrrt_pkg::*;

    localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
    localparam int                       REPORT_LIMIT = 10;

    // shadow copy of the rule slots
    logic [COUNT_W-1:0]       slots_used;
    logic                     rule_live    [RULE_SLOTS];
    logic [7:0]               rule_slave   [RULE_SLOTS];
    logic [15:0]              rule_reg     [RULE_SLOTS];
    logic [2:0]               rule_kind    [RULE_SLOTS];
    logic signed [DATA_W-1:0] rule_operand [RULE_SLOTS];

    rrrt_out_t expected_q [$];
    rrrt_out_t oldest;

    function automatic void clear_rules();
        int i;
        slots_used = '0;
        for (i = 0; i < RULE_SLOTS; i++)
        begin
            rule_live[i]    = 1'b0;
            rule_slave[i]   = '0;
            rule_reg[i]     = '0;
            rule_kind[i]    = '0;
            rule_operand[i] = '0;
        end
    endfunction

    // key lookup ignores the live bit, -1 when the key was never stored
    function automatic int stored_slot(logic [7:0] sa, logic [15:0] ra);
        int i;
        int slot;
        slot = -1;
        for (i = 0; i < slots_used; i++)
        begin
            if (slot < 0 && rule_slave[i] == sa && rule_reg[i] == ra)
                slot = i;
        end
        return slot;
    endfunction

    function automatic logic signed [DATA_W-1:0] rewrite_value(
        logic [2:0]               kind,
        logic signed [DATA_W-1:0] v,
        logic signed [DATA_W-1:0] p
    );
        case (kind)
            KIND_SET: return p;
            KIND_ADD: return v + p;
            KIND_SUB: return v - p;
            KIND_MUL: return v * p;
            KIND_DIV:
            begin
                if (p == 0)
                    return v;
                // the one quotient that does not fit wraps back onto itself
                if (v == MOST_NEG && p == -1)
                    return v;
                return v / p;
            end
            default: return v;
        endcase
    endfunction

    function automatic rrrt_out_t table_outcome(rrrt_in_t item);
        rrrt_out_t res;
        int        i;
        int        slot;
        logic      hit;
        res = '0;
        case (item.op)
            OP_APPLY:
            begin
                res.value_out = item.value_in;
                hit = 1'b0;
                for (i = 0; i < slots_used; i++)
                begin
                    if (!hit && rule_live[i] && rule_slave[i] == item.slave_addr
                        && rule_reg[i] == item.reg_num)
                    begin
                        hit = 1'b1;
                        res.value_out = rewrite_value(rule_kind[i], item.value_in,
                                                      rule_operand[i]);
                    end
                end
            end
            OP_ADD:
            begin
                slot = stored_slot(item.slave_addr, item.reg_num);
                if (slot < 0 && slots_used < RULE_SLOTS)
                begin
                    slot = int'(slots_used);
                    rule_slave[slot] = item.slave_addr;
                    rule_reg[slot]   = item.reg_num;
                    slots_used       = slots_used + 1'b1;
                end
                if (slot < 0)
                    res.status = 1'b1;
                else
                begin
                    rule_live[slot]    = 1'b1;
                    rule_kind[slot]    = item.mod_kind;
                    rule_operand[slot] = item.mod_param;
                end
            end
            OP_REMOVE:
            begin
                slot = stored_slot(item.slave_addr, item.reg_num);
                if (slot < 0)
                    res.status = 1'b1;
                else
                    rule_live[slot] = 1'b0;
            end
            default: clear_rules();
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_rules();
            expected_q.delete();
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            // a returning result always belongs to an earlier transfer
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("%0t: result with nothing outstanding: value %h status %b",
                                 $realtime, out_data.value_out, out_data.status);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    oldest = expected_q.pop_front();
                    if (out_data.value_out !== oldest.value_out
                        || out_data.status !== oldest.status)
                    begin
                        if (mismatch_count < REPORT_LIMIT)
                            $display("%0t: value exp %h got %h, status exp %b got %b",
                                     $realtime, oldest.value_out, out_data.value_out,
                                     oldest.status, out_data.status);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(table_outcome(in_data));
            outstanding <= expected_q.size();
        end
    end

endmodule

>>> verif/tb_register_rewrite_rule_table_unit.sv
// ----------------------------------------------------------------------------
// tb_register_rewrite_rule_table_unit
// Drives apply, add, remove and clear traffic into the rule table: a directed
// run over the arithmetic corner cases, then rule sequences on a small key
// pool, table refills past capacity and raw noise, with random gaps on both
// sides. The checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_register_rewrite_rule_table_unit;
    import rrrt_pkg::*;

    localparam int         TOTAL_ITEMS  = 1550;
    localparam int         PRESSURE_AT  = 700;
    localparam int         POOL_KEYS    = 24;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         DRAIN_CYCLES = 80;
    localparam logic [2:0] KIND_NONE    = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    rrrt_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    rrrt_out_t out_data;

    int        mismatch_count;
    int        outstanding;
    int        sent;
    int        stall_cycles;
    logic      quiet;

    logic [7:0]  pool_slave [POOL_KEYS];
    logic [15:0] pool_reg   [POOL_KEYS];

    register_rewrite_rule_table_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    rule_table_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rrrt_in_t rule_item(
        logic [1:0]               op,
        logic [7:0]               sa,
        logic [15:0]              ra,
        logic [2:0]               kind,
        logic signed [DATA_W-1:0] param,
        logic signed [DATA_W-1:0] value
    );
        rrrt_in_t item;
        item.op         = op;
        item.slave_addr = sa;
        item.reg_num    = ra;
        item.mod_kind   = kind;
        item.mod_param  = param;
        item.value_in   = value;
        return item;
    endfunction

    // an arithmetic edge half the time, otherwise a small or full random value
    function automatic logic signed [DATA_W-1:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return $urandom_range(20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // valid is only lowered in a gap, so back-to-back transfers keep it high
    task automatic send_item(input rrrt_in_t item);
        int gap;
        if (!quiet && $urandom_range(99) < 28)
        begin
            gap = $urandom_range(60, 1);
            repeat (gap)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= quiet || ($urandom_range(99) >= 28);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int         k;
        int         len;
        int         mode;
        int         pick;
        logic [1:0] op;
        logic [95:0] raw;
        rrrt_in_t   noise;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        sent  = 0;
        quiet = 1'b0;

        // distinct keys, some sharing a slave address
        for (k = 0; k < POOL_KEYS; k++)
        begin
            pool_slave[k] = (k % 3 == 1) ? pool_slave[k - 1] : 8'($urandom);
            pool_reg[k]   = (16'($urandom) & 16'hFFE0) | 16'(k);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(rule_item(OP_APPLY,  8'hFF, 16'hFFFF, 3'($urandom), $urandom,
                            32'sh7fff_ffff));
        send_item(rule_item(OP_REMOVE, 8'h00, 16'h0000, 3'($urandom), $urandom, $urandom));
        send_item(rule_item(OP_ADD,    8'hFF, 16'hFFFF, KIND_SET, 32'sh8000_0000, $urandom));
        send_item(rule_item(OP_APPLY,  8'hFF, 16'hFFFF, 3'($urandom), $urandom, 32'sh1234));
        send_item(rule_item(OP_ADD,    8'hFF, 16'hFFFF, KIND_DIV, -1, $urandom));
        send_item(rule_item(OP_APPLY,  8'hFF, 16'hFFFF, 3'($urandom), $urandom,
                            32'sh8000_0000));
        send_item(rule_item(OP_ADD,    8'h00, 16'h0000, KIND_DIV, 0, $urandom));
        send_item(rule_item(OP_APPLY,  8'h00, 16'h0000, 3'($urandom), $urandom, -7));
        send_item(rule_item(OP_ADD,    8'h5A, 16'hA5A5, KIND_MUL, -1, $urandom));
        send_item(rule_item(OP_APPLY,  8'h5A, 16'hA5A5, 3'($urandom), $urandom,
                            32'sh7fff_ffff));
        send_item(rule_item(OP_ADD,    8'hA5, 16'h5A5A, KIND_ADD, 32'sh7fff_ffff, $urandom));
        send_item(rule_item(OP_APPLY,  8'hA5, 16'h5A5A, 3'($urandom), $urandom, 1));
        send_item(rule_item(OP_ADD,    8'h01, 16'h8000, KIND_SUB, 1, $urandom));
        send_item(rule_item(OP_APPLY,  8'h01, 16'h8000, 3'($urandom), $urandom,
                            32'sh8000_0000));
        send_item(rule_item(OP_ADD,    8'h80, 16'h0001, KIND_NONE, $urandom, $urandom));
        send_item(rule_item(OP_APPLY,  8'h80, 16'h0001, 3'($urandom), $urandom, $urandom));
        // removed rule stops matching, removing it again still succeeds
        send_item(rule_item(OP_REMOVE, 8'hFF, 16'hFFFF, 3'($urandom), $urandom, $urandom));
        send_item(rule_item(OP_APPLY,  8'hFF, 16'hFFFF, 3'($urandom), $urandom, 5));
        send_item(rule_item(OP_REMOVE, 8'hFF, 16'hFFFF, 3'($urandom), $urandom, $urandom));
        send_item(rule_item(OP_ADD,    8'hFF, 16'hFFFF, KIND_DIV, -3, $urandom));
        send_item(rule_item(OP_APPLY,  8'hFF, 16'hFFFF, 3'($urandom), $urandom, 7));
        send_item(rule_item(OP_APPLY,  8'h00, 16'h00FF, 3'($urandom), $urandom, $urandom));
        send_item(rule_item(OP_CLEAR,  8'($urandom), 16'($urandom), 3'($urandom),
                            $urandom, $urandom));
        send_item(rule_item(OP_APPLY,  8'h5A, 16'hA5A5, 3'($urandom), $urandom,
                            32'sh7fff_ffff));

        while (sent < TOTAL_ITEMS)
        begin
            quiet = (sent >= 300 && sent < 550);
            mode  = $urandom_range(99);
            if (mode < 10)
            begin
                // empty the table, then add past capacity so the last adds bounce
                send_item(rule_item(OP_CLEAR, 8'($urandom), 16'($urandom), 3'($urandom),
                                    $urandom, $urandom));
                for (k = 0; k < RULE_SLOTS + 3; k++)
                    send_item(rule_item(OP_ADD, pool_slave[k], pool_reg[k],
                                        3'($urandom_range(7)), pick_operand(), $urandom));
            end
            else if (mode < 80)
            begin
                len = $urandom_range(12, 4);
                repeat (len)
                begin
                    k    = ($urandom_range(99) < 75) ? $urandom_range(11)
                                                     : $urandom_range(POOL_KEYS - 1);
                    pick = $urandom_range(99);
                    if (pick < 50)
                        op = OP_APPLY;
                    else if (pick < 80)
                        op = OP_ADD;
                    else if (pick < 96)
                        op = OP_REMOVE;
                    else
                        op = OP_CLEAR;
                    send_item(rule_item(op, pool_slave[k], pool_reg[k],
                                        3'($urandom_range(7)), pick_operand(),
                                        pick_operand()));
                end
            end
            else
            begin
                raw   = {$urandom, $urandom, $urandom};
                noise = raw[$bits(rrrt_in_t)-1:0];
                send_item(noise);
            end

            if (sent >= PRESSURE_AT && sent < PRESSURE_AT + 40)
            begin
                // hold off until the table has answered everything
                in_valid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
            end
        end

        in_valid <= 1'b0;
        quiet = 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> register_rewrite_rule_table_unit.f
rtl/rrrt_pkg.sv
rtl/register_rewrite_rule_table_unit.sv
rtl/rrrt_checker.sv
verif/rule_table_checker.sv
verif/tb_register_rewrite_rule_table_unit.sv
